[design/fbig_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fbig_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int NUM_FANS      = 2;
  localparam int BOOST_MIN     = 0;
  localparam int BOOST_MAX     = 100;

  localparam int IDX_W     = $clog2(MAX_INTERVALS);
  localparam int FAN_W     = 1;
  localparam int ADDR_W    = FAN_W + IDX_W;
  localparam int CNT_W     = 5;
  localparam int TEMP_W    = 8;
  localparam int TIME_W    = 32;
  localparam int BOOST_W   = 7;
  localparam int EBOOST_W  = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TABLE  = 2'd1,
    OP_MANUAL = 2'd2,
    OP_AUTO   = 2'd3
  } op_t;

  localparam logic [1:0] PH_INITIAL = 2'd0;
  localparam logic [1:0] PH_UPSHIFT = 2'd1;
  localparam logic [1:0] PH_NORMAL  = 2'd2;

  localparam logic [1:0] PD_NONE = 2'd0;
  localparam logic [1:0] PD_UP   = 2'd1;
  localparam logic [1:0] PD_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENDING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPAMOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MINHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MINWAIT  = 3'd6;

  typedef struct packed {
    logic signed [TEMP_W-1:0] lo;
    logic signed [TEMP_W-1:0] hi;
    logic [EBOOST_W-1:0]      boost;
  } entry_t;

  function automatic logic [BOOST_W-1:0] clamp_boost(input logic [BOOST_W-1:0] b);
    if (b < BOOST_W'(BOOST_MIN)) begin
      return BOOST_W'(BOOST_MIN);
    end else if (b > BOOST_W'(BOOST_MAX)) begin
      return BOOST_W'(BOOST_MAX);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[design/fan_boost_interval_governor.sv]
// Table write, manual boost and restart items, and samples for a fan in manual mode, go straight
// to the finish state. Other samples: a scan of the intervals in use (n, one table read per cycle)
// that stops at the first match, a decide state, then as needed time checks through one shared
// subtract/compare unit, table reads and apply, then the finish state that registers the result.
// One item at a time; busy stays high until the result strobe.
// Reset (synchronous, rst_n low): all fans automatic, initial phase, no interval, boost 0.
// The result is shown on out_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module fan_boost_interval_governor
  import fbig_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire [1:0]                  in_op,
  input  wire [FAN_W-1:0]            in_fan,
  input  wire signed [TEMP_W-1:0]    in_temperature,
  input  wire [TIME_W-1:0]           in_now_seconds,
  input  wire [IDX_W-1:0]            in_entry_index,
  input  wire signed [TEMP_W-1:0]    in_entry_low_temp,
  input  wire signed [TEMP_W-1:0]    in_entry_high_temp,
  input  wire [EBOOST_W-1:0]         in_entry_boost,
  input  wire [BOOST_W-1:0]          in_manual_boost,
  output logic                       out_valid,
  output logic [FAN_W-1:0]           out_fan,
  output logic [BOOST_W-1:0]         out_boost,
  output logic                       out_boost_written,
  output logic [IDX_W-1:0]           out_interval,
  output logic                       out_interval_valid,
  output logic [1:0]                 out_phase,
  output logic [1:0]                 out_pending,
  output logic                       out_no_match,
  input  wire                        cfg_we,
  input  wire [CFG_IDX_W-1:0]        cfg_index,
  input  wire [CFG_W-1:0]            cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_CHK_PEND,
    ST_CHK_UPHOLD,
    ST_CHK_SETTLE,
    ST_CHK_HELD,
    ST_CHK_PROD,
    ST_RD_CUR,
    ST_CHK_FLOOR,
    ST_RD_TGT,
    ST_APPLY,
    ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [CNT_W-1:0]   count_r;
  logic [CFG_W-1:0]   pend_secs_r;
  logic [CFG_W-1:0]   uphold_r;
  logic [BOOST_W-1:0] upamount_r;
  logic [BOOST_W-1:0] hyst_r;
  logic [CFG_W-1:0]   minhold_r;
  logic [CFG_W-1:0]   minwait_r;

  // per-fan state
  logic [IDX_W-1:0]   cur_r      [NUM_FANS];
  logic               ok_r       [NUM_FANS];
  logic [1:0]         phase_r    [NUM_FANS];
  logic [1:0]         pend_r     [NUM_FANS];
  logic [TIME_W-1:0]  since_r    [NUM_FANS];
  logic [TIME_W-1:0]  set_r      [NUM_FANS];
  logic [TIME_W-1:0]  settle_r   [NUM_FANS];
  logic [BOOST_W-1:0] boost_r    [NUM_FANS];
  logic               auto_r     [NUM_FANS];

  // item context
  logic [FAN_W-1:0]         fan_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [TIME_W-1:0]        now_r;
  logic [CNT_W-1:0]         n_r;
  logic [CNT_W-1:0]         scan_i_r;
  logic [IDX_W-1:0]         cmp_i_r;
  logic                     cmp_v_r;
  logic [IDX_W-1:0]         hit_r;
  logic [IDX_W-1:0]         tgt_r;
  logic                     up_r;
  logic                     down_r;
  logic [TIME_W-1:0]        held_r;
  logic                     wrote_r;
  logic                     nomatch_r;

  // result registers
  logic                     out_valid_r;
  logic [FAN_W-1:0]         out_fan_r;
  logic [BOOST_W-1:0]       out_boost_r;
  logic                     out_written_r;
  logic [IDX_W-1:0]         out_interval_r;
  logic                     out_ivalid_r;
  logic [1:0]               out_phase_r;
  logic [1:0]               out_pending_r;
  logic                     out_nomatch_r;

  // table memory
  entry_t              mem [NUM_FANS*MAX_INTERVALS];
  entry_t              rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic                accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (op_t'(in_op) == OP_TABLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{in_fan, in_entry_index}] <= '{lo: in_entry_low_temp, hi: in_entry_high_temp,
                                         boost: in_entry_boost};
    end
    rd_data_r <= mem[rd_addr];
  end

  logic [IDX_W-1:0] cur;
  assign cur = cur_r[fan_r];

  always_comb begin
    case (state_r)
      ST_SCAN:   rd_addr = {fan_r, scan_i_r[IDX_W-1:0]};
      ST_RD_CUR: rd_addr = {fan_r, cur};
      default:   rd_addr = {fan_r, tgt_r};
    endcase
  end

  // shared elapsed-time unit
  logic [TIME_W-1:0] t_sel;
  logic [CFG_W-1:0]  thr_sel;
  logic [TIME_W-1:0] diff;
  logic              pass;

  always_comb begin
    case (state_r)
      ST_CHK_PEND: begin
        t_sel   = since_r[fan_r];
        thr_sel = pend_secs_r;
      end
      ST_CHK_UPHOLD: begin
        t_sel   = set_r[fan_r];
        thr_sel = uphold_r;
      end
      ST_CHK_SETTLE: begin
        t_sel   = settle_r[fan_r];
        thr_sel = minwait_r;
      end
      default: begin
        t_sel   = set_r[fan_r];
        thr_sel = '0;
      end
    endcase
  end

  assign diff = now_r - t_sel;
  assign pass = (diff >= TIME_W'(thr_sel));

  logic [IDX_W-1:0]      gap;
  logic [TIME_W+IDX_W-1:0] prod;
  logic                  prod_ok;
  assign gap     = cur - hit_r;
  assign prod    = (TIME_W+IDX_W)'(held_r) * (TIME_W+IDX_W)'(gap);
  assign prod_ok = (prod >= (TIME_W+IDX_W)'(minhold_r));

  logic signed [TEMP_W+1:0] floor_t;
  logic signed [TEMP_W+1:0] t_ext;
  logic                     floor_ok;
  assign floor_t  = {{2{rd_data_r.lo[TEMP_W-1]}}, rd_data_r.lo}
                    - $signed({3'b000, hyst_r});
  assign t_ext    = {{2{temp_r[TEMP_W-1]}}, temp_r};
  assign floor_ok = (t_ext <= floor_t);

  logic match;
  assign match = (rd_data_r.lo <= temp_r) && (rd_data_r.hi >= temp_r);

  // apply of an interval boost
  logic [EBOOST_W:0]  up_sum;
  logic [BOOST_W-1:0] ap_boost;
  logic [1:0]         ap_phase;
  logic               ap_settle;

  assign up_sum = {1'b0, rd_data_r.boost} + (EBOOST_W+1)'(upamount_r);

  always_comb begin
    ap_settle = 1'b0;
    if (rd_data_r.boost <= EBOOST_W'(BOOST_MIN)) begin
      ap_boost = BOOST_W'(BOOST_MIN);
      ap_phase = PH_NORMAL;
    end else if (rd_data_r.boost >= EBOOST_W'(BOOST_MAX)) begin
      ap_boost = BOOST_W'(BOOST_MAX);
      ap_phase = PH_NORMAL;
    end else if (up_r) begin
      ap_phase = PH_UPSHIFT;
      ap_boost = (up_sum > (EBOOST_W+1)'(BOOST_MAX)) ? BOOST_W'(BOOST_MAX)
                                                    : up_sum[BOOST_W-1:0];
    end else begin
      ap_boost  = rd_data_r.boost[BOOST_W-1:0];
      ap_phase  = PH_NORMAL;
      ap_settle = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CNT_W'(1);
      pend_secs_r <= '0;
      uphold_r    <= '0;
      upamount_r  <= '0;
      hyst_r      <= '0;
      minhold_r   <= '0;
      minwait_r   <= '0;
      for (int f = 0; f < NUM_FANS; f++) begin
        cur_r[f]    <= '0;
        ok_r[f]     <= 1'b0;
        phase_r[f]  <= PH_INITIAL;
        pend_r[f]   <= PD_NONE;
        since_r[f]  <= '0;
        set_r[f]    <= '0;
        settle_r[f] <= '0;
        boost_r[f]  <= '0;
        auto_r[f]   <= 1'b1;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COUNT:    count_r     <= cfg_wdata[CNT_W-1:0];
          REG_PENDING:  pend_secs_r <= cfg_wdata;
          REG_UPHOLD:   uphold_r    <= cfg_wdata;
          REG_UPAMOUNT: upamount_r  <= cfg_wdata[BOOST_W-1:0];
          REG_HYST:     hyst_r      <= cfg_wdata[BOOST_W-1:0];
          REG_MINHOLD:  minhold_r   <= cfg_wdata;
          REG_MINWAIT:  minwait_r   <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            fan_r     <= in_fan;
            temp_r    <= in_temperature;
            now_r     <= in_now_seconds;
            n_r       <= (count_r > CNT_W'(MAX_INTERVALS)) ? CNT_W'(MAX_INTERVALS) : count_r;
            scan_i_r  <= '0;
            cmp_v_r   <= 1'b0;
            wrote_r   <= 1'b0;
            nomatch_r <= 1'b0;
            state_r   <= ST_FIN;
            unique case (op_t'(in_op))
              OP_SAMPLE: begin
                if (auto_r[in_fan]) begin
                  state_r <= ST_SCAN;
                end
              end
              OP_TABLE: ;
              OP_MANUAL: begin
                auto_r[in_fan]  <= 1'b0;
                boost_r[in_fan] <= clamp_boost(in_manual_boost);
                wrote_r         <= 1'b1;
              end
              OP_AUTO: begin
                if (!auto_r[in_fan]) begin
                  auto_r[in_fan]  <= 1'b1;
                  phase_r[in_fan] <= PH_INITIAL;
                end
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          if (cmp_v_r && match) begin
            hit_r   <= cmp_i_r;
            state_r <= ST_DECIDE;
          end else if (scan_i_r < n_r) begin
            cmp_i_r  <= scan_i_r[IDX_W-1:0];
            cmp_v_r  <= 1'b1;
            scan_i_r <= scan_i_r + CNT_W'(1);
          end else begin
            nomatch_r <= 1'b1;
            hit_r     <= cur;
            state_r   <= ok_r[fan_r] ? ST_DECIDE : ST_FIN;
          end
        end

        ST_DECIDE: begin
          state_r <= ST_FIN;
          if (phase_r[fan_r] == PH_INITIAL) begin
            pend_r[fan_r] <= PD_NONE;
            tgt_r         <= hit_r;
            up_r          <= 1'b1;
            state_r       <= ST_RD_TGT;
          end else if (hit_r > cur) begin
            if (pend_r[fan_r] == PD_UP) begin
              tgt_r   <= hit_r;
              up_r    <= 1'b1;
              down_r  <= 1'b0;
              state_r <= ST_CHK_PEND;
            end else begin
              pend_r[fan_r]  <= PD_UP;
              since_r[fan_r] <= now_r;
            end
          end else if (phase_r[fan_r] == PH_UPSHIFT) begin
            pend_r[fan_r] <= PD_NONE;
            if (pend_r[fan_r] == PD_NONE) begin
              tgt_r   <= cur;
              up_r    <= 1'b0;
              state_r <= ST_CHK_UPHOLD;
            end
          end else if (hit_r < cur && phase_r[fan_r] == PH_NORMAL) begin
            if (pend_r[fan_r] == PD_DOWN) begin
              tgt_r   <= cur - IDX_W'(1);
              up_r    <= 1'b0;
              down_r  <= 1'b1;
              state_r <= ST_CHK_PEND;
            end else begin
              pend_r[fan_r]  <= PD_DOWN;
              since_r[fan_r] <= now_r;
            end
          end else begin
            pend_r[fan_r] <= PD_NONE;
          end
        end

        ST_CHK_PEND: begin
          if (!pass) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= down_r ? ST_CHK_SETTLE : ST_RD_TGT;
          end
        end

        ST_CHK_UPHOLD: state_r <= pass ? ST_RD_TGT : ST_FIN;

        ST_CHK_SETTLE: state_r <= pass ? ST_CHK_HELD : ST_FIN;

        ST_CHK_HELD: begin
          held_r  <= diff;
          state_r <= ST_CHK_PROD;
        end

        ST_CHK_PROD: state_r <= prod_ok ? ST_RD_CUR : ST_FIN;

        ST_RD_CUR: state_r <= ST_CHK_FLOOR;

        ST_CHK_FLOOR: state_r <= floor_ok ? ST_RD_TGT : ST_FIN;

        ST_RD_TGT: state_r <= ST_APPLY;

        ST_APPLY: begin
          boost_r[fan_r] <= ap_boost;
          phase_r[fan_r] <= ap_phase;
          if (ap_settle) begin
            settle_r[fan_r] <= now_r;
          end
          if (!ok_r[fan_r] || cur != tgt_r) begin
            ok_r[fan_r]  <= 1'b1;
            cur_r[fan_r] <= tgt_r;
            set_r[fan_r] <= now_r;
          end
          wrote_r <= 1'b1;
          state_r <= ST_FIN;
        end

        ST_FIN: begin
          out_valid_r    <= 1'b1;
          out_fan_r      <= fan_r;
          out_boost_r    <= boost_r[fan_r];
          out_written_r  <= wrote_r;
          out_interval_r <= ok_r[fan_r] ? cur : '0;
          out_ivalid_r   <= ok_r[fan_r];
          out_phase_r    <= phase_r[fan_r];
          out_pending_r  <= pend_r[fan_r];
          out_nomatch_r  <= nomatch_r;
          state_r        <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fan            = out_fan_r;
  assign out_boost          = out_boost_r;
  assign out_boost_written  = out_written_r;
  assign out_interval       = out_interval_r;
  assign out_interval_valid = out_ivalid_r;
  assign out_phase          = out_phase_r;
  assign out_pending        = out_pending_r;
  assign out_no_match       = out_nomatch_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_boost_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_boost <= BOOST_W'(BOOST_MAX))
    else $error("boost above limit");

endmodule

`default_nettype wire
